// File: rtl/fsk4ps_pkg.sv
// ----------------------------------------------------------------------------
// fsk4ps_pkg
// shared constants, types and the symbol mapping of the 4-fsk pulse shaper
// ----------------------------------------------------------------------------
package fsk4ps_pkg;

	localparam int TAP_COUNT  = 41;
	localparam int UPSAMPLE   = 5;
	localparam int COEF_W     = 16;
	localparam int TAP_W      = $clog2(TAP_COUNT);
	localparam int PH_W       = $clog2(UPSAMPLE);
	localparam int HIST_W     = 3;
	localparam int PROD_W     = COEF_W + 2;
	localparam int ACC_W      = COEF_W + $clog2(3 * TAP_COUNT);
	localparam int GAIN_W     = 8;
	localparam int SCALED_W   = ACC_W + GAIN_W + 1;
	localparam int FRAC       = COEF_W - 1;
	localparam int Q_W        = SCALED_W - FRAC;
	localparam int SAMPLE_W   = 8;
	localparam int SYMS       = 4;
	localparam int SYM_W      = $clog2(SYMS);

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(40);

	// action codes carried in tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MOD  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// dibit to symbol level
	function automatic logic signed [HIST_W-1:0] level_of(input logic [1:0] dibit);
		logic signed [HIST_W-1:0] lv;
		unique case (dibit)
			2'b00: lv = HIST_W'(1);
			2'b01: lv = HIST_W'(3);
			2'b10: lv = -HIST_W'(1);
			2'b11: lv = -HIST_W'(3);
			default: lv = '0;
		endcase
		return lv;
	endfunction

endpackage

// File: rtl/fsk4_symbol_pulse_shaper_top.sv
// ----------------------------------------------------------------------------
// fsk4_symbol_pulse_shaper_top
// 4-level fsk modulator: byte stream in, fir-shaped signed 8-bit samples out
// ----------------------------------------------------------------------------
// flow: a byte beat is taken only while idle, and the next byte beat only after
//   the last sample beat of the byte; a coefficient load beat is taken while
//   idle too. every sample is computed by the mac walking all 41 taps, then
//   scaled, and held until the sink takes it
// reset: arst_n clears the symbol delay line, sequencer and gain (to 40);
//   the coefficient memory holds garbage until loaded
module fsk4_symbol_pulse_shaper_top (
	input  logic        clk,
	input  logic        arst_n,
	// gain register write
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,      // output_gain
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // coef_index[5:0], coef_value[21:6], data_byte[29:22]
	input  logic        s_axis_tuser,   // action
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // sample[7:0]
	output logic        m_axis_tuser,   // clipped
	output logic        m_axis_tlast
);

	fsk4ps_pkg::state_t state_q, state_d;

	// input beat fields
	logic [5:0]  in_coef_index;
	logic [15:0] in_coef_value;
	logic [7:0]  in_data_byte;
	logic        s_beat;
	logic        m_beat;

	assign in_coef_index = s_axis_tdata[5:0];
	assign in_coef_value = s_axis_tdata[21:6];
	assign in_data_byte  = s_axis_tdata[29:22];
	assign s_beat        = s_axis_tvalid && s_axis_tready;
	assign m_beat        = m_axis_tvalid && m_axis_tready;

	// registers
	logic [fsk4ps_pkg::GAIN_W-1:0]  gain_q;
	logic [7:0]                     byte_q;       // current dibit sits in [7:6]
	logic [fsk4ps_pkg::SYM_W-1:0]   sym_q;        // dibit number within the byte
	logic [fsk4ps_pkg::PH_W-1:0]    phase_q;      // upsampling phase
	logic [fsk4ps_pkg::TAP_W-1:0]   tap_q;        // tap being issued to the mac
	logic                           drain_q;
	logic signed [fsk4ps_pkg::HIST_W-1:0] hist_q [fsk4ps_pkg::TAP_COUNT];

	// mac pipeline
	logic                                  v_s1, v_s2;
	logic signed [fsk4ps_pkg::HIST_W-1:0]  hist_s1;
	logic signed [fsk4ps_pkg::COEF_W-1:0]  coef_s1;
	logic signed [fsk4ps_pkg::PROD_W-1:0]  prod_d, prod_s2;
	logic signed [fsk4ps_pkg::ACC_W-1:0]   acc_q;
	logic signed [fsk4ps_pkg::SCALED_W-1:0] scaled_d, scaled_q, biased_d;
	logic signed [fsk4ps_pkg::Q_W-1:0]     quot_d;

	// output register
	logic [fsk4ps_pkg::SAMPLE_W-1:0] sample_q;
	logic                            clip_q;
	logic                            last_q;

	// coefficient memory, one write and one registered read port
	logic signed [fsk4ps_pkg::COEF_W-1:0] coef_mem [fsk4ps_pkg::TAP_COUNT];

	logic signed [fsk4ps_pkg::HIST_W-1:0] push_level;
	logic                                 load_ok;
	logic                                 phase_end;
	logic                                 sym_end;

	localparam logic signed [fsk4ps_pkg::Q_W-1:0] Q_HI =
		fsk4ps_pkg::Q_W'(2 ** (fsk4ps_pkg::SAMPLE_W - 1) - 1);
	localparam logic signed [fsk4ps_pkg::Q_W-1:0] Q_LO =
		fsk4ps_pkg::Q_W'(-(2 ** (fsk4ps_pkg::SAMPLE_W - 1)));
	localparam logic signed [fsk4ps_pkg::SCALED_W-1:0] TRUNC_BIAS =
		fsk4ps_pkg::SCALED_W'(2 ** fsk4ps_pkg::FRAC - 1);

	assign phase_end  = (phase_q == fsk4ps_pkg::PH_W'(fsk4ps_pkg::UPSAMPLE - 1));
	assign sym_end    = (sym_q == fsk4ps_pkg::SYM_W'(fsk4ps_pkg::SYMS - 1));
	// zero-stuffing: the symbol itself only enters on the last phase
	assign push_level = phase_end ? fsk4ps_pkg::level_of(byte_q[7:6]) : '0;
	assign load_ok    = ({1'b0, in_coef_index} < 7'(fsk4ps_pkg::TAP_COUNT));

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsk4ps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			fsk4ps_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (s_axis_tuser == fsk4ps_pkg::ACT_MOD)) begin
					state_d = fsk4ps_pkg::ST_PUSH;
				end
			end
			fsk4ps_pkg::ST_PUSH: begin
				state_d = fsk4ps_pkg::ST_MAC;
			end
			fsk4ps_pkg::ST_MAC: begin
				if (tap_q == fsk4ps_pkg::TAP_W'(fsk4ps_pkg::TAP_COUNT - 1)) begin
					state_d = fsk4ps_pkg::ST_DRAIN;
				end
			end
			fsk4ps_pkg::ST_DRAIN: begin
				if (drain_q) begin
					state_d = fsk4ps_pkg::ST_SCALE;
				end
			end
			fsk4ps_pkg::ST_SCALE: begin
				state_d = fsk4ps_pkg::ST_EMIT;
			end
			fsk4ps_pkg::ST_EMIT: begin
				state_d = fsk4ps_pkg::ST_WAIT;
			end
			fsk4ps_pkg::ST_WAIT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_d = last_q ? fsk4ps_pkg::ST_IDLE : fsk4ps_pkg::ST_PUSH;
				end
			end
			default: state_d = fsk4ps_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// gain register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= fsk4ps_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// coefficient memory: loads from input beats, read by tap counter
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_beat && (s_axis_tuser == fsk4ps_pkg::ACT_LOAD) && load_ok) begin
			coef_mem[in_coef_index[fsk4ps_pkg::TAP_W-1:0]] <=
				in_coef_value[fsk4ps_pkg::COEF_W-1:0];
		end
		coef_s1 <= coef_mem[tap_q];
	end

	// ------------------------------------------------------------------
	// symbol delay line: circulates once per sample so the mac reads every
	// entry from the head, oldest first; a push drops the oldest and adds the newest
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsk4ps_pkg::TAP_COUNT; i++) begin
				hist_q[i] <= '0;
			end
		end else if (state_q == fsk4ps_pkg::ST_PUSH || state_q == fsk4ps_pkg::ST_MAC) begin
			for (int i = 0; i < fsk4ps_pkg::TAP_COUNT - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[fsk4ps_pkg::TAP_COUNT-1] <=
				(state_q == fsk4ps_pkg::ST_PUSH) ? push_level : hist_q[0];
		end
	end

	// ------------------------------------------------------------------
	// counters and byte position
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q   <= '0;
			drain_q <= 1'b0;
			sym_q   <= '0;
			phase_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == fsk4ps_pkg::ST_MAC);
			v_s2 <= v_s1;
			if (s_beat) begin
				sym_q   <= '0;
				phase_q <= '0;
			end
			if (state_q == fsk4ps_pkg::ST_PUSH) begin
				tap_q <= '0;
			end else if (state_q == fsk4ps_pkg::ST_MAC) begin
				tap_q <= tap_q + 1'b1;
			end
			drain_q <= (state_q == fsk4ps_pkg::ST_DRAIN) ? !drain_q : 1'b0;
			if (m_beat) begin
				if (phase_end) begin
					phase_q <= '0;
					sym_q   <= sym_q + 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			byte_q <= in_data_byte;
		end else if (m_beat && phase_end) begin
			byte_q <= {byte_q[5:0], 2'b00};
		end
	end

	// ------------------------------------------------------------------
	// shared multiply-accumulate unit: level times coefficient, one tap
	// per cycle, then the finished sum scaled by the gain
	// ------------------------------------------------------------------
	assign prod_d   = hist_s1 * coef_s1;
	assign scaled_d = acc_q * $signed({1'b0, gain_q});

	always_ff @(posedge clk) begin
		hist_s1 <= hist_q[0];
		prod_s2 <= prod_d;
		if (state_q == fsk4ps_pkg::ST_PUSH) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + fsk4ps_pkg::ACC_W'(prod_s2);
		end
		if (state_q == fsk4ps_pkg::ST_SCALE) begin
			scaled_q <= scaled_d;
		end
	end

	// ------------------------------------------------------------------
	// truncate toward zero, saturate, output register
	// ------------------------------------------------------------------
	assign biased_d = scaled_q + (scaled_q[fsk4ps_pkg::SCALED_W-1] ? TRUNC_BIAS : '0);
	assign quot_d   = biased_d[fsk4ps_pkg::SCALED_W-1:fsk4ps_pkg::FRAC];

	always_ff @(posedge clk) begin
		if (state_q == fsk4ps_pkg::ST_EMIT) begin
			last_q <= sym_end && phase_end;
			if (quot_d > Q_HI) begin
				sample_q <= Q_HI[fsk4ps_pkg::SAMPLE_W-1:0];
				clip_q   <= 1'b1;
			end else if (quot_d < Q_LO) begin
				sample_q <= Q_LO[fsk4ps_pkg::SAMPLE_W-1:0];
				clip_q   <= 1'b1;
			end else begin
				sample_q <= quot_d[fsk4ps_pkg::SAMPLE_W-1:0];
				clip_q   <= 1'b0;
			end
		end
	end

	assign m_axis_tdata = sample_q;
	assign m_axis_tuser = clip_q;
	assign m_axis_tlast = last_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// one item at a time: never taking input while a sample is offered
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while sample pending");

	// products only leave the pipeline while the taps are walked or the pipeline drains
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == fsk4ps_pkg::ST_MAC || state_q == fsk4ps_pkg::ST_DRAIN))
		else $error("mac product outside accumulation window");

	// the accumulator is complete before scaling
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fsk4ps_pkg::ST_SCALE) |-> (!v_s1 && !v_s2))
		else $error("scaling with mac pipeline not drained");

	// the final beat of a byte returns the block to accepting input
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_beat && m_axis_tlast) |=> s_axis_tready)
		else $error("not idle after last beat of byte");

	// tlast marks exactly the twentieth sample
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (sym_end && phase_end)))
		else $error("tlast out of step with byte position");

endmodule
